// ===== sv/dlq_pkg.sv =====
// Shared types, codes and defaults for the doubly linked queue manager.
package dlq_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int NODE_W         = 6;

  // command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [NODE_W-1:0] node_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] popped_node;
    logic              is_empty;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] last_node;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request, launch table reads
    logic exec;   // apply update, write result register
    logic clr;    // clear one linked bit
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // clear pointer at last slot
    logic out_busy;  // result register full and not taken this cycle
  } ctl_sts_t;

endpackage

// ===== sv/dlq_ctrl.sv =====
// Controller state machine: clear pass, accept, execute.
module dlq_ctrl
  import dlq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the new beat
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/dlq_datapath.sv =====
// Datapath: slot tables, head/tail/empty registers and the result register.
module dlq_datapath
  import dlq_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  ctl_cmd_t cmd,
  output ctl_sts_t sts,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rsp_t     rsp
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int WIDE  = (IDX_W > NODE_W) ? IDX_W : NODE_W;

  // slot tables
  logic             linked_mem [SLOT_COUNT];
  logic [IDX_W-1:0] prev_mem   [SLOT_COUNT];
  logic [IDX_W-1:0] next_mem   [SLOT_COUNT];

  // list registers
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic             empty;
  logic [IDX_W-1:0] clr_addr;

  // captured request and table read data
  logic [1:0]       cmd_q;
  logic [IDX_W-1:0] tgt;
  logic             tgt_ok;
  logic             linked_rd;
  logic [IDX_W-1:0] prev_rd;
  logic [IDX_W-1:0] next_rd;

  // request decode
  logic [WIDE-1:0]  idx_wide;
  logic [IDX_W-1:0] idx_slot;
  logic             idx_ok;
  logic [IDX_W-1:0] rd_addr;

  assign idx_wide = WIDE'(req.node_index);
  assign idx_slot = idx_wide[IDX_W-1:0];
  assign idx_ok   = 32'(req.node_index) < SLOT_COUNT;
  assign rd_addr  = (req.command == CMD_POP) ? head : idx_slot;

  // update logic
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_next;
  logic             empty_next;
  logic [1:0]       status;
  logic [IDX_W-1:0] popped;
  logic             lk_we;
  logic             lk_val;
  logic             pv_we;
  logic [IDX_W-1:0] pv_addr;
  logic [IDX_W-1:0] pv_val;
  logic             nx_we;
  logic [IDX_W-1:0] nx_addr;
  logic [IDX_W-1:0] nx_val;
  logic             unlink;
  logic             is_head;
  logic             is_tail;

  assign is_head = (tgt == head);
  assign is_tail = (tgt == tail);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    status     = ST_DONE;
    popped     = '0;
    lk_we      = 1'b0;
    lk_val     = 1'b0;
    pv_we      = 1'b0;
    pv_addr    = tgt;
    pv_val     = tail;
    nx_we      = 1'b0;
    nx_addr    = tail;
    nx_val     = tgt;
    unlink     = 1'b0;
    case (cmd_q)
      CMD_PUSH: begin
        if (!tgt_ok || linked_rd) begin
          status = ST_REFUSED;
        end else begin
          lk_we  = 1'b1;
          lk_val = 1'b1;
          if (empty) begin
            head_next  = tgt;
            tail_next  = tgt;
            empty_next = 1'b0;
          end else begin
            nx_we     = 1'b1;
            pv_we     = 1'b1;
            tail_next = tgt;
          end
        end
      end
      CMD_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          popped = tgt;
          unlink = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!tgt_ok || !linked_rd) begin
          status = ST_REFUSED;
        end else begin
          unlink = 1'b1;
        end
      end
      CMD_QUERY: begin
      end
      default: begin
      end
    endcase

    if (unlink) begin
      lk_we  = 1'b1;
      lk_val = 1'b0;
      if (is_head && is_tail) begin
        empty_next = 1'b1;
      end else begin
        if (is_head) begin
          head_next = next_rd;
        end else begin
          nx_we   = 1'b1;
          nx_addr = prev_rd;
          nx_val  = next_rd;
        end
        if (is_tail) begin
          tail_next = prev_rd;
        end else begin
          pv_we   = 1'b1;
          pv_addr = next_rd;
          pv_val  = prev_rd;
        end
      end
    end
  end

  // result formatting to node field width
  logic [WIDE-1:0] pop_w;
  logic [WIDE-1:0] head_w;
  logic [WIDE-1:0] tail_w;
  rsp_t            rsp_next;

  assign pop_w  = WIDE'(popped);
  assign head_w = WIDE'(head_next);
  assign tail_w = WIDE'(tail_next);

  always_comb begin
    rsp_next.status      = status;
    rsp_next.popped_node = pop_w[NODE_W-1:0];
    rsp_next.is_empty    = empty_next;
    rsp_next.first_node  = empty_next ? '0 : head_w[NODE_W-1:0];
    rsp_next.last_node   = empty_next ? '0 : tail_w[NODE_W-1:0];
  end

  assign sts.clr_last = (clr_addr == IDX_W'(SLOT_COUNT - 1));
  assign sts.out_busy = rsp_valid && !rsp_ready;

  // linked bits: cleared by the sweep, then at most one write per command
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      linked_mem[clr_addr] <= 1'b0;
    end else if (cmd.exec && lk_we) begin
      linked_mem[tgt] <= lk_val;
    end
    if (cmd.load) begin
      linked_rd <= linked_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && pv_we) begin
      prev_mem[pv_addr] <= pv_val;
    end
    if (cmd.load) begin
      prev_rd <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && nx_we) begin
      next_mem[nx_addr] <= nx_val;
    end
    if (cmd.load) begin
      next_rd <= next_mem[rd_addr];
    end
  end

  // captured request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= req.command;
      tgt    <= rd_addr;
      tgt_ok <= idx_ok;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      empty     <= 1'b1;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.exec) begin
        head      <= head_next;
        tail      <= tail_next;
        empty     <= empty_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/doubly_linked_queue_manager_unit.sv =====
// Top level of the doubly linked queue manager: controller plus datapath.
//
//   channel  | handshake              | payload | beat
//   ---------+------------------------+---------+------------------------------
//   request  | req_valid / req_ready  | req     | command, node_index
//   response | rsp_valid / rsp_ready  | rsp     | status, popped, empty, ends
//
// A request is first captured and the slot table reads launched (linked,
// prev, next at the target slot); the execute step then applies the update
// and loads the response register. After reset a clear pass zeroes one linked
// bit per cycle across all SLOT_COUNT slots, with req_ready low. A response
// waiting on rsp_ready does not block the next request beat; only the execute
// step holds until the response register frees.
module doubly_linked_queue_manager_unit
  import dlq_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  dlq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dlq_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
